// ===== src/lzr_pkg.sv =====
// shared types and constants for the lzss ring decompressor
`default_nettype none

package lzr_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int LONGEST_COPY   = 18;
  localparam int SHORTEST_COPY  = 3;
  localparam int CNT_W          = 24;
  localparam int LEN_W          = 5;
  localparam int APB_AW         = 2;
  localparam int APB_DW         = 32;

  localparam logic [CNT_W-1:0]  LIMIT_RESET      = {CNT_W{1'b1}};
  localparam logic [7:0]        SPACE_BYTE       = 8'h20;
  localparam logic [APB_AW-1:0] REG_OUTPUT_LIMIT = 2'd0;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_ITEM,
    PH_HIGH
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIT,
    S_READ,
    S_COPY
  } ctl_state_t;

  typedef struct packed {
    logic take;
    logic emit_lit;
    logic ring_read;
    logic emit_copy;
    logic refuse;
    logic finish;
  } lzr_cmd_t;

  typedef struct packed {
    logic start_lit;
    logic start_match;
    logic allowed;
    logic slot_free;
    logic copy_last;
  } lzr_status_t;

endpackage

`default_nettype wire

// ===== src/lzr_if.sv =====
// valid/ready channel interfaces for compressed input and decompressed output
`default_nettype none

interface lzr_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in_stream;

  modport source (output valid, output in_byte, output last_in_stream, input ready);
  modport sink (input valid, input in_byte, input last_in_stream, output ready);
endinterface

interface lzr_out_if import lzr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic             last_of_run;
  logic [CNT_W-1:0] total_written;

  modport source (output valid, output out_byte, output last_of_run, output total_written,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input total_written,
                output ready);
endinterface

`default_nettype wire

// ===== src/lzr_ctrl.sv =====
// control state machine: sequences literal emits and match copies
`default_nettype none

module lzr_ctrl import lzr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lzr_status_t st,
  output lzr_cmd_t    cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && st.start_lit) begin
          state_next = S_LIT;
        end else if (in_valid && st.start_match) begin
          state_next = S_READ;
        end
      end
      S_LIT: begin
        if (!st.allowed || st.slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_COPY;
      end
      S_COPY: begin
        if (!st.allowed) begin
          state_next = S_IDLE;
        end else if (st.slot_free) begin
          state_next = st.copy_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_LIT: begin
        if (!st.allowed) begin
          cmd.refuse = 1'b1;
          cmd.finish = 1'b1;
        end else if (st.slot_free) begin
          cmd.emit_lit = 1'b1;
          cmd.finish   = 1'b1;
        end
      end
      S_READ: begin
        cmd.ring_read = 1'b1;
      end
      S_COPY: begin
        if (!st.allowed) begin
          cmd.refuse = 1'b1;
          cmd.finish = 1'b1;
        end else if (st.slot_free) begin
          cmd.emit_copy = 1'b1;
          cmd.finish    = st.copy_last;
        end
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_lit || cmd.emit_copy) |-> (st.allowed && st.slot_free))
    else $error("emit issued without room or past the limit");

  a_copy_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> ($past(state) == S_READ || $past(state) == S_COPY))
    else $error("copy state entered without a ring read");

endmodule

`default_nettype wire

// ===== src/lzr_dp.sv =====
// datapath: parser registers, history ring, counters and output register
`default_nettype none

module lzr_dp import lzr_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic [CNT_W-1:0] limit,
  input  lzr_cmd_t         cmd,
  output lzr_status_t      st,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [CNT_W-1:0] out_total
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] WP_START  = AW'(RING_DEPTH - LONGEST_COPY);
  localparam logic [AW:0]   FILL_FULL = (AW + 1)'(RING_DEPTH);

  logic [7:0] ring [RING_DEPTH];

  phase_t           phase;
  logic [7:0]       flags;
  logic [2:0]       idx;
  logic [7:0]       held;
  logic [7:0]       lit_byte;
  logic             last_q;
  logic [AW-1:0]    wp;
  logic [AW-1:0]    pos;
  logic [LEN_W-1:0] remain;
  logic [CNT_W-1:0] count;
  logic [AW:0]      fill;
  logic             stopped;
  logic [7:0]       rdata;
  logic             rd_valid;

  logic             emit;
  logic [7:0]       emit_data;
  logic             emit_last;
  logic [CNT_W-1:0] count_inc;
  logic             restart;
  logic [AW-1:0]    rd_offset;

  assign st.start_lit   = !stopped && (phase == PH_ITEM) && flags[idx];
  assign st.start_match = !stopped && (phase == PH_HIGH);
  assign st.allowed     = count < limit;
  assign st.slot_free   = !out_valid || out_ready;
  assign st.copy_last   = (remain == '0);

  assign emit      = cmd.emit_lit || cmd.emit_copy;
  assign count_inc = count + 1'b1;
  assign emit_data = cmd.emit_lit ? lit_byte : (rd_valid ? rdata : SPACE_BYTE);
  // a copy byte ends the run when the length is used up or the limit is reached
  assign emit_last = cmd.emit_lit || (remain == '0) || (count_inc >= limit);
  // bytes that start nothing restart right away; the rest restart when finished
  assign restart   = (cmd.take && in_last && !st.start_lit && !st.start_match)
                  || (cmd.finish && last_q);
  // entries written since the stream began form one run starting at WP_START
  assign rd_offset = pos - WP_START;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_FLAG;
      flags   <= '0;
      idx     <= '0;
      wp      <= WP_START;
      count   <= '0;
      fill    <= '0;
      stopped <= 1'b0;
    end else begin
      if (cmd.take && !stopped) begin
        unique case (phase)
          PH_FLAG: begin
            flags <= in_byte;
            idx   <= '0;
            phase <= PH_ITEM;
          end
          PH_ITEM: begin
            if (!flags[idx]) begin
              phase <= PH_HIGH;
            end
          end
          PH_HIGH: begin
            phase <= PH_HIGH;
          end
          default: phase <= PH_FLAG;
        endcase
      end
      if (emit) begin
        wp    <= wp + 1'b1;
        count <= count_inc;
        if (fill != FILL_FULL) begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.refuse) begin
        stopped <= 1'b1;
      end
      if (cmd.finish) begin
        idx   <= idx + 1'b1;
        phase <= (idx == 3'd7) ? PH_FLAG : PH_ITEM;
      end
      if (restart) begin
        phase   <= PH_FLAG;
        flags   <= '0;
        idx     <= '0;
        wp      <= WP_START;
        count   <= '0;
        fill    <= '0;
        stopped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lit_byte <= in_byte;
      last_q   <= in_last;
      pos      <= AW'({in_byte[7:4], held});
      remain   <= LEN_W'(in_byte[3:0]) + LEN_W'(SHORTEST_COPY - 1);
      if (phase == PH_ITEM && !flags[idx]) begin
        held <= in_byte;
      end
    end else if (cmd.emit_copy) begin
      pos    <= pos + 1'b1;
      remain <= remain - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ring[wp] <= emit_data;
    end
    if (cmd.ring_read) begin
      rdata    <= ring[pos];
      rd_valid <= {1'b0, rd_offset} < fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= emit_data;
      out_last  <= emit_last;
      out_total <= count_inc;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("ring fill count beyond ring depth");

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_total != '0))
    else $error("output transfer with zero running total");

endmodule

`default_nettype wire

// ===== src/lzss_ring_decompressor.sv =====
// top level: lzss decoder with a 4096-byte history ring, apb limit register
// a flag byte or a token low byte is only taken; a literal is then emitted once the output is free
// a match token's high byte starts a copy of 3 to 18 bytes, and each copied byte is
// a read then a write on the single-port history ring
// output register holds one result, so input is taken while a result waits
// rst is synchronous; ring contents track a written-range count, no clearing pass
`default_nettype none

module lzss_ring_decompressor import lzr_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lzr_in_if.sink            in_ch,
  lzr_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] limit;
  lzr_cmd_t         cmd;
  lzr_status_t      st;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_OUTPUT_LIMIT) ? APB_DW'(limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_OUTPUT_LIMIT) begin
      limit <= pwdata[CNT_W-1:0];
    end
  end

  lzr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lzr_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.last_in_stream),
    .limit     (limit),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_of_run),
    .out_total (out_ch.total_written)
  );

endmodule

`default_nettype wire

// ===== sim/lzr_checker.sv =====
// checker: decodes the compressed stream beside the block and compares every output byte
module lzr_checker import lzr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lzr_in_if                 in_ch,
  lzr_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fault_total,
  output int                backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]       data;
    logic             run_end;
    logic [CNT_W-1:0] count;
  } out_beat_t;

  logic [7:0]       hist [RING_DEPTH_DEF];
  logic [11:0]      wr_pos;
  phase_t           phase;
  logic [7:0]       flags;
  logic [2:0]       slot;
  logic [7:0]       low_hold;
  logic [CNT_W-1:0] sent_count;
  logic             halted;
  logic [CNT_W-1:0] limit_q;
  out_beat_t        beats_due [$];

  task automatic log_fault(input string msg);
    $display("%0t lzr_checker: %s", $realtime, msg);
    fault_total++;
  endtask

  task automatic restart_stream();
    foreach (hist[i]) hist[i] = SPACE_BYTE;
    wr_pos     = 12'(RING_DEPTH_DEF - LONGEST_COPY);
    phase      = PH_FLAG;
    flags      = '0;
    slot       = '0;
    low_hold   = '0;
    sent_count = '0;
    halted     = 1'b0;
  endtask

  task automatic advance_slot();
    if (slot == 3'd7) begin
      slot  = '0;
      phase = PH_FLAG;
    end else begin
      slot  = slot + 3'd1;
      phase = PH_ITEM;
    end
  endtask

  // once the limit refuses a byte, nothing more comes out until the stream ends
  task automatic emit_out(input logic [7:0] b, output bit ok);
    if (halted || sent_count >= limit_q) begin
      halted = 1'b1;
      ok     = 1'b0;
    end else begin
      hist[wr_pos] = b;
      wr_pos       = wr_pos + 12'd1;
      sent_count   = sent_count + 1'b1;
      beats_due.push_back('{b, 1'b0, sent_count});
      ok = 1'b1;
    end
  endtask

  task automatic decode_in(input logic [7:0] b, input logic last);
    int          made;
    bit          ok;
    logic [11:0] src;
    int          len;
    made = 0;
    if (!halted) begin
      case (phase)
        PH_FLAG: begin
          flags = b;
          slot  = '0;
          phase = PH_ITEM;
        end
        PH_ITEM: begin
          if (flags[slot]) begin
            emit_out(b, ok);
            if (ok) made++;
            advance_slot();
          end else begin
            low_hold = b;
            phase    = PH_HIGH;
          end
        end
        default: begin
          src = {b[7:4], low_hold};
          len = int'(b[3:0]) + SHORTEST_COPY;
          // byte by byte, so an overlapping copy picks up what it just wrote
          for (int j = 0; j < len; j++) begin
            emit_out(hist[src + 12'(j)], ok);
            if (!ok) break;
            made++;
          end
          advance_slot();
        end
      endcase
    end
    if (made > 0) beats_due[beats_due.size() - 1].run_end = 1'b1;
    if (last) restart_stream();
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      limit_q = LIMIT_RESET;
      restart_stream();
      beats_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_OUTPUT_LIMIT)
        limit_q = pwdata[CNT_W-1:0];
      if (out_ch.valid && out_ch.ready) begin
        if (beats_due.size() == 0) begin
          log_fault($sformatf("unexpected output byte %h", out_ch.out_byte));
        end else begin
          want = beats_due.pop_front();
          if (out_ch.out_byte !== want.data)
            log_fault($sformatf("out_byte %h, predicted %h (count %0d)",
                                out_ch.out_byte, want.data, want.count));
          if (out_ch.last_of_run !== want.run_end)
            log_fault($sformatf("last_of_run %b, predicted %b (count %0d)",
                                out_ch.last_of_run, want.run_end, want.count));
          if (out_ch.total_written !== want.count)
            log_fault($sformatf("total_written %0d, predicted %0d",
                                out_ch.total_written, want.count));
        end
      end
      if (in_ch.valid && in_ch.ready) decode_in(in_ch.in_byte, in_ch.last_in_stream);
    end
    backlog = beats_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top: drives compressed streams and limit writes into the decompressor
module tb_top import lzr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fault_total;
  int                backlog;
  int                items_sent = 0;
  int                hold_left  = 0;
  bit                tx_steady  = 1'b0;
  bit                rx_steady  = 1'b0;

  lzr_in_if  in_ch ();
  lzr_out_if out_ch ();

  lzss_ring_decompressor u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lzr_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fault_total (fault_total),
    .backlog     (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off counted here when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= rx_steady || ($urandom_range(99) >= 29);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic push_byte(input logic [7:0] b, input logic last);
    while (!tx_steady && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.in_byte        <= b;
    in_ch.last_in_stream <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // drop valid and wait until the block has nothing left to do
  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (backlog == 0);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_OUTPUT_LIMIT;
    pwdata  <= APB_DW'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // kind below 80: well-formed, below 90: cut inside a token, else noise
  task automatic send_stream(input int kind);
    logic [7:0]  pkt [$];
    logic [7:0]  fl;
    int          groups;
    int          stop_at;
    logic [11:0] pos;
    if (kind < 0) kind = $urandom_range(99);
    if (kind < 90) begin
      groups = $urandom_range(1, 3);
      for (int g = 0; g < groups; g++) begin
        fl = 8'($urandom);
        pkt.push_back(fl);
        stop_at = (g == groups - 1 && kind < 80) ? $urandom_range(1, 8) : 8;
        for (int k = 0; k < stop_at; k++) begin
          if (fl[k]) begin
            pkt.push_back(8'($urandom));
          end else begin
            // half the matches point at or just past where this stream began writing
            if ($urandom_range(1) == 1)
              pos = 12'(RING_DEPTH_DEF - LONGEST_COPY + $urandom_range(0, 60));
            else
              pos = 12'($urandom);
            pkt.push_back(pos[7:0]);
            pkt.push_back({pos[11:8], 4'($urandom)});
          end
        end
      end
      if (kind >= 80) begin
        pkt.push_back(8'($urandom) & 8'hFE);
        pkt.push_back(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
    end
    foreach (pkt[i]) push_byte(pkt[i], i == pkt.size() - 1);
  endtask

  initial begin
    int               s;
    logic [CNT_W-1:0] lim;
    rst                  = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.in_byte        = '0;
    in_ch.last_in_stream = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // literals at both extremes, a full-length match from the blank ring,
    // an overlapping copy, a match that wraps the ring, and a dropped token
    write_limit(LIMIT_RESET);
    push_byte(8'hF5, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b1);

    // zero limit: nothing at all comes out
    settle();
    write_limit('0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b1);

    // limit reached on a literal, then raised: output stays stopped
    settle();
    write_limit(CNT_W'(2));
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    settle();
    write_limit(LIMIT_RESET);
    push_byte(8'h04, 1'b1);

    // limit reached partway through a match
    settle();
    write_limit(CNT_W'(5));
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b1);
    settle();
    write_limit(LIMIT_RESET);

    s = 0;
    while (items_sent < 240) begin
      if (s == 3) begin
        // receiver holds off while several streams keep coming
        in_ch.valid <= 1'b0;
        @(posedge clk);
        hold_left = 400;
        @(negedge clk);
        repeat (3) send_stream(0);
      end else begin
        send_stream(-1);
      end
      tx_steady = (s >= 10 && s < 18);
      rx_steady = (s >= 10 && s < 18);
      if ($urandom_range(99) < 12) begin
        settle();
        case ($urandom_range(3))
          0:       lim = CNT_W'($urandom_range(0, 30));
          1:       lim = CNT_W'($urandom);
          default: lim = LIMIT_RESET;
        endcase
        write_limit(lim);
      end
      s++;
    end

    in_ch.valid <= 1'b0;
    wait (backlog == 0);
    repeat (60) @(posedge clk);
    if (fault_total == 0 && backlog == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== lzss_ring_decompressor.f =====
src/lzr_pkg.sv
src/lzr_if.sv
src/lzr_ctrl.sv
src/lzr_dp.sv
src/lzss_ring_decompressor.sv
sim/lzr_checker.sv
sim/tb_top.sv
